// File: sv/huffman_stream_decoder_defines.svh
// ============================================================================
// Huffman stream decoder assertion macros
// Concurrent checks clocked on clk, quiet while rst_n is low.
// ============================================================================
`ifndef HUFFMAN_STREAM_DECODER_DEFINES_SVH
`define HUFFMAN_STREAM_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define HSD_ASSERT(label, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HSD_NEVER(label, expr, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define HSD_ASSERT(label, prop, msg)
`define HSD_NEVER(label, expr, msg)
`endif
`endif

// File: sv/hsd_pkg.sv
// ============================================================================
// Huffman stream decoder package
// Transaction types, event codes and state encodings.
// ============================================================================
package hsd_pkg;

    localparam int SYM_W = 8;
    localparam logic [SYM_W-1:0] LEAF_MARK = 8'h31;

    localparam logic [1:0] EV_SYM    = 2'd0;
    localparam logic [1:0] EV_ZERO   = 2'd1;
    localparam logic [1:0] EV_OVF    = 2'd2;
    localparam logic [1:0] EV_SINGLE = 2'd3;

    typedef struct packed {
        logic [SYM_W-1:0] data_byte;
        logic             file_start;
    } in_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [1:0]       event_res;
        logic             run_last;
        logic             stream_end;
    } out_t;

    typedef enum logic [5:0] {
        S_IN    = 6'b000001,
        S_ADD   = 6'b000010,
        S_POP   = 6'b000100,
        S_EMIT  = 6'b001000,
        S_WALK  = 6'b010000,
        S_FLUSH = 6'b100000
    } state_t;

    typedef enum logic [4:0] {
        PH_SKIP   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_COUNT  = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_IDLE   = 5'b10000
    } phase_t;

endpackage

// File: sv/hsd_ram.sv
// ============================================================================
// Huffman stream decoder RAM
// Single write port, single read port, registered read data.
// ============================================================================
module hsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/huffman_stream_decoder.sv
// ============================================================================
// Huffman stream decoder
// Builds a pre-order coded tree in node memory, then walks it per code bit.
// ============================================================================
// A compressed file enters one byte per transaction; a byte with file_start
// set restarts the parse. A header byte is taken in S_IN and, if it adds a
// node, written in S_ADD; a right child also costs a stack memory read in
// S_ADD before the parent is patched in S_POP. Count bytes stay in S_IN. A
// data byte enters in S_IN, then S_WALK issues the first node read and steps
// its eight code bits through the single read port of the node memory, and
// S_FLUSH releases the last symbol; a stalled output can hold a symbol back
// and pause the walk, and a byte that completes the count stops early. Node
// and stack memories hold nothing useful after reset and need no clearing pass.
`include "huffman_stream_decoder_defines.svh"

module huffman_stream_decoder #(
    parameter int MAX_NODES = 512
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  hsd_pkg::in_t byte_data,
    output logic         res_valid,
    input  logic         res_stall,
    output hsd_pkg::out_t res_data
);

    import hsd_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int NW = 1 + SYM_W + IW;

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [CW-1:0]    node_count_reg, node_count_next;
    logic [CW-1:0]    stack_top_reg, stack_top_next;
    logic             top_pend_reg, top_pend_next;
    logic             leaf_next_reg, leaf_next_next;
    logic [2:0]       cnt_idx_reg, cnt_idx_next;
    logic [63:0]      remaining_reg, remaining_next;
    logic [IW-1:0]    walk_reg, walk_next;
    logic [IW-1:0]    cur_right_reg, cur_right_next;
    logic [IW-1:0]    root_right_reg, root_right_next;
    logic [3:0]       bits_left_reg, bits_left_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             hold_valid_reg, hold_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             add_leaf_reg, add_leaf_next;
    logic [SYM_W-1:0] byte_reg, byte_next;
    logic [1:0]       evt_reg, evt_next;
    logic [IW-1:0]    new_node_reg, new_node_next;
    logic [IW-1:0]    pend_addr_reg, pend_addr_next;
    out_t             hold_reg, hold_next;
    out_t             out_reg, out_next;

    logic             node_we;
    logic [IW-1:0]    node_waddr, node_raddr;
    logic [NW-1:0]    node_wdata, node_rdata;
    logic             stack_we;
    logic [IW-1:0]    stack_waddr, stack_raddr;
    logic [IW-1:0]    stack_wdata, stack_rdata;

    logic             accept;
    logic             out_free;
    logic [IW-1:0]    cur_node;
    logic [CW-1:0]    top_dec;
    logic [63:0]      rem_fill;
    logic [63:0]      rem_dec;
    logic             sym_end;
    logic             frozen;
    logic             stop;
    logic [IW-1:0]    w_sel;
    logic [IW-1:0]    r_sel;
    logic [2:0]       bit_idx;
    logic [IW-1:0]    child;
    logic             walk_live;

    hsd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    hsd_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    assign byte_stall = (state_reg != S_IN);
    assign accept     = byte_valid && !byte_stall;
    assign out_free   = !out_valid_reg || !res_stall;
    assign res_valid  = out_valid_reg;
    assign res_data   = out_reg;

    assign cur_node = node_count_reg[IW-1:0];
    assign top_dec  = CW'(stack_top_reg - 1'b1);
    assign rem_fill = remaining_reg | (64'(byte_data.data_byte) << {cnt_idx_reg, 3'b000});
    assign rem_dec  = remaining_reg - 64'd1;
    assign sym_end  = (remaining_reg == 64'd1);
    assign bit_idx  = 3'(bits_left_reg - 4'd1);
    assign walk_live = (state_reg == S_WALK) && rd_pend_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        node_count_next = node_count_reg;
        stack_top_next  = stack_top_reg;
        top_pend_next   = top_pend_reg;
        leaf_next_next  = leaf_next_reg;
        cnt_idx_next    = cnt_idx_reg;
        remaining_next  = remaining_reg;
        walk_next       = walk_reg;
        cur_right_next  = cur_right_reg;
        root_right_next = root_right_reg;
        bits_left_next  = bits_left_reg;
        rd_pend_next    = rd_pend_reg;
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg && res_stall;
        add_leaf_next   = add_leaf_reg;
        byte_next       = byte_reg;
        evt_next        = evt_reg;
        new_node_next   = new_node_reg;
        pend_addr_next  = pend_addr_reg;
        hold_next       = hold_reg;
        out_next        = out_reg;
        node_we         = 1'b0;
        node_waddr      = '0;
        node_wdata      = '0;
        node_raddr      = '0;
        stack_we        = 1'b0;
        stack_waddr     = '0;
        stack_wdata     = '0;
        stack_raddr     = '0;
        frozen          = 1'b0;
        stop            = 1'b0;
        w_sel           = walk_reg;
        r_sel           = cur_right_reg;
        child           = '0;

        unique case (state_reg)
            S_IN:
            begin
                if (accept)
                begin
                    byte_next = byte_data.data_byte;
                    if (byte_data.file_start)
                    begin
                        phase_next      = PH_HEADER;
                        node_count_next = '0;
                        stack_top_next  = '0;
                        top_pend_next   = 1'b0;
                        leaf_next_next  = 1'b0;
                        cnt_idx_next    = '0;
                        remaining_next  = '0;
                        walk_next       = '0;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_SKIP:
                            begin
                                phase_next = PH_HEADER;
                            end
                            PH_HEADER:
                            begin
                                if (leaf_next_reg)
                                begin
                                    leaf_next_next = 1'b0;
                                    add_leaf_next  = 1'b1;
                                    state_next     = S_ADD;
                                end
                                else if (byte_data.data_byte == '0)
                                begin
                                    evt_next   = EV_ZERO;
                                    phase_next = PH_IDLE;
                                    state_next = S_EMIT;
                                end
                                else if (byte_data.data_byte == LEAF_MARK)
                                begin
                                    leaf_next_next = 1'b1;
                                end
                                else
                                begin
                                    add_leaf_next = 1'b0;
                                    byte_next     = '0;
                                    state_next    = S_ADD;
                                end
                            end
                            PH_COUNT:
                            begin
                                remaining_next = rem_fill;
                                cnt_idx_next   = 3'(cnt_idx_reg + 3'd1);
                                if (cnt_idx_reg == 3'd7)
                                begin
                                    if (rem_fill == 64'd0 || rem_fill[63])
                                    begin
                                        phase_next = PH_IDLE;
                                    end
                                    else
                                    begin
                                        phase_next     = PH_DATA;
                                        walk_next      = '0;
                                        cur_right_next = root_right_reg;
                                    end
                                end
                            end
                            PH_DATA:
                            begin
                                bits_left_next = 4'd8;
                                rd_pend_next   = 1'b0;
                                state_next     = S_WALK;
                            end
                            PH_IDLE:
                            begin
                                phase_next = PH_IDLE;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_ADD:
            begin
                if (node_count_reg == CW'(MAX_NODES))
                begin
                    evt_next   = EV_OVF;
                    phase_next = PH_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    node_we         = 1'b1;
                    node_waddr      = cur_node;
                    node_wdata      = {add_leaf_reg, byte_reg, {IW{1'b0}}};
                    node_count_next = CW'(node_count_reg + 1'b1);
                    new_node_next   = cur_node;
                    state_next      = S_IN;
                    if (stack_top_reg == '0)
                    begin
                        if (add_leaf_reg)
                        begin
                            evt_next   = EV_SINGLE;
                            phase_next = PH_IDLE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            stack_we       = 1'b1;
                            stack_waddr    = '0;
                            stack_wdata    = cur_node;
                            stack_top_next = CW'(1);
                            top_pend_next  = 1'b1;
                        end
                    end
                    else if (top_pend_reg)
                    begin
                        top_pend_next = 1'b0;
                        if (!add_leaf_reg)
                        begin
                            stack_we       = 1'b1;
                            stack_waddr    = stack_top_reg[IW-1:0];
                            stack_wdata    = cur_node;
                            stack_top_next = CW'(stack_top_reg + 1'b1);
                            top_pend_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        stack_raddr = top_dec[IW-1:0];
                        state_next  = S_POP;
                    end
                end
            end

            S_POP:
            begin
                node_we        = 1'b1;
                node_waddr     = stack_rdata;
                node_wdata     = {1'b0, {SYM_W{1'b0}}, new_node_reg};
                stack_top_next = top_dec;
                if (stack_rdata == '0)
                begin
                    root_right_next = new_node_reg;
                end
                if (!add_leaf_reg)
                begin
                    stack_we       = 1'b1;
                    stack_waddr    = top_dec[IW-1:0];
                    stack_wdata    = new_node_reg;
                    stack_top_next = stack_top_reg;
                    top_pend_next  = 1'b1;
                end
                else if (top_dec == '0)
                begin
                    phase_next     = PH_COUNT;
                    cnt_idx_next   = '0;
                    remaining_next = '0;
                end
                state_next = S_IN;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{symbol: '0, event_res: evt_reg,
                                       run_last: 1'b1, stream_end: 1'b0};
                    state_next     = S_IN;
                end
            end

            S_WALK:
            begin
                if (rd_pend_reg)
                begin
                    if (node_rdata[NW-1])
                    begin
                        if (hold_valid_reg && !out_free)
                        begin
                            frozen = 1'b1;
                        end
                        else
                        begin
                            if (hold_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_next       = hold_reg;
                            end
                            hold_valid_next = 1'b1;
                            hold_next       = '{symbol: node_rdata[NW-2 -: SYM_W],
                                                event_res: EV_SYM, run_last: 1'b0,
                                                stream_end: sym_end};
                            remaining_next  = rem_dec;
                            w_sel           = '0;
                            r_sel           = root_right_reg;
                            if (sym_end)
                            begin
                                stop       = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        w_sel = pend_addr_reg;
                        r_sel = node_rdata[IW-1:0];
                    end
                end

                if (frozen)
                begin
                    node_raddr = pend_addr_reg;
                end
                else
                begin
                    walk_next      = w_sel;
                    cur_right_next = r_sel;
                    if (!stop && bits_left_reg != 4'd0)
                    begin
                        child          = byte_reg[bit_idx] ? r_sel : IW'(w_sel + 1'b1);
                        node_raddr     = child;
                        pend_addr_next = child;
                        rd_pend_next   = 1'b1;
                        bits_left_next = 4'(bits_left_reg - 4'd1);
                    end
                    else
                    begin
                        rd_pend_next = 1'b0;
                        state_next   = S_FLUSH;
                    end
                end
            end

            S_FLUSH:
            begin
                if (hold_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_next        = hold_reg;
                        out_next.run_last = 1'b1;
                        hold_valid_next = 1'b0;
                        state_next      = S_IN;
                    end
                end
                else
                begin
                    state_next = S_IN;
                end
            end

            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IN;
            phase_reg      <= PH_SKIP;
            node_count_reg <= '0;
            stack_top_reg  <= '0;
            top_pend_reg   <= 1'b0;
            leaf_next_reg  <= 1'b0;
            cnt_idx_reg    <= '0;
            remaining_reg  <= '0;
            walk_reg       <= '0;
            cur_right_reg  <= '0;
            root_right_reg <= '0;
            bits_left_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            add_leaf_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            node_count_reg <= node_count_next;
            stack_top_reg  <= stack_top_next;
            top_pend_reg   <= top_pend_next;
            leaf_next_reg  <= leaf_next_next;
            cnt_idx_reg    <= cnt_idx_next;
            remaining_reg  <= remaining_next;
            walk_reg       <= walk_next;
            cur_right_reg  <= cur_right_next;
            root_right_reg <= root_right_next;
            bits_left_reg  <= bits_left_next;
            rd_pend_reg    <= rd_pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            add_leaf_reg   <= add_leaf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        evt_reg       <= evt_next;
        new_node_reg  <= new_node_next;
        pend_addr_reg <= pend_addr_next;
        hold_reg      <= hold_next;
        out_reg       <= out_next;
    end

    `HSD_ASSERT(a_top_within_count, stack_top_reg <= node_count_reg, "stack deeper than tree")
    `HSD_ASSERT(a_count_within_max, node_count_reg <= CW'(MAX_NODES), "node count overrun")
    `HSD_NEVER(a_hold_idle, state_reg == S_IN && hold_valid_reg, "held symbol left behind")
    `HSD_ASSERT(a_walk_in_tree, walk_live |-> CW'(pend_addr_reg) < node_count_reg, "walk off tree")

endmodule

// File: tb/testbench.sv
// ============================================================================
// Huffman stream decoder testbench
// Streams compressed files (pre-order tree header, 64-bit count, code bits)
// into the decoder and checks every decoded symbol and error event against
// an in-bench tree builder and walker, under random idling and back-pressure.
// ============================================================================
module testbench;
    import hsd_pkg::*;

    localparam int NODE_LIMIT = 512;
    localparam int CYCLE_LIMIT = 600000;

    localparam int KIND_GOOD = 0;
    localparam int KIND_ZERO = 1;
    localparam int KIND_NEG  = 2;
    localparam int KIND_CUT  = 3;

    class huff_scoreboard;
        phase_t      ph;
        bit          is_leaf[NODE_LIMIT];
        logic [7:0]  leaf_sym[NODE_LIMIT];
        int          left_idx[NODE_LIMIT];
        int          right_idx[NODE_LIMIT];
        int          open_node[NODE_LIMIT];
        bit          open_right[NODE_LIMIT];
        int          node_total;
        int          open_top;
        bit          sym_next;
        int          count_idx;
        logic [63:0] remain;
        int          walk;
        out_t        batch[$];
        out_t        expected[$];
        int          errors;
        int          symbols_seen;
        int          events_seen;

        function new();
            errors = 0;
            symbols_seen = 0;
            events_seen = 0;
            restart();
        endfunction

        function void restart();
            ph = PH_SKIP;
            node_total = 0;
            open_top = 0;
            sym_next = 0;
            count_idx = 0;
            remain = '0;
            walk = 0;
        endfunction

        function void emit(logic [7:0] s, logic [1:0] ev, bit fin);
            out_t r;
            r.symbol = s;
            r.event_res = ev;
            r.run_last = 1'b0;
            r.stream_end = fin;
            batch.push_back(r);
        endfunction

        function void add_node(bit lf, logic [7:0] s);
            int n;
            if (node_total >= NODE_LIMIT)
            begin
                ph = PH_IDLE;
                emit(8'h00, EV_OVF, 1'b0);
                return;
            end
            n = node_total++;
            is_leaf[n] = lf;
            leaf_sym[n] = s;
            left_idx[n] = 0;
            right_idx[n] = 0;
            if (open_top == 0)
            begin
                if (lf)
                begin
                    ph = PH_IDLE;
                    emit(8'h00, EV_SINGLE, 1'b0);
                    return;
                end
            end
            else if (!open_right[open_top-1])
            begin
                left_idx[open_node[open_top-1]] = n;
                open_right[open_top-1] = 1'b1;
            end
            else
            begin
                right_idx[open_node[open_top-1]] = n;
                open_top--;
            end
            if (!lf)
            begin
                open_node[open_top] = n;
                open_right[open_top] = 1'b0;
                open_top++;
            end
            else if (open_top == 0)
            begin
                ph = PH_COUNT;
                count_idx = 0;
                remain = '0;
            end
        endfunction

        function void note(in_t t);
            logic [7:0] b;
            int i;
            b = t.data_byte;
            batch = {};
            if (t.file_start)
                restart();
            case (ph)
                PH_SKIP: ph = PH_HEADER;
                PH_HEADER:
                    if (sym_next)
                    begin
                        sym_next = 0;
                        add_node(1'b1, b);
                    end
                    else if (b == 8'h00)
                    begin
                        ph = PH_IDLE;
                        emit(8'h00, EV_ZERO, 1'b0);
                    end
                    else if (b == LEAF_MARK)
                    begin
                        sym_next = 1;
                    end
                    else
                    begin
                        add_node(1'b0, 8'h00);
                    end
                PH_COUNT:
                begin
                    remain = remain | (64'(b) << (8 * count_idx));
                    count_idx++;
                    if (count_idx == 8)
                    begin
                        count_idx = 0;
                        if (remain == 0 || remain[63])
                        begin
                            ph = PH_IDLE;
                        end
                        else
                        begin
                            ph = PH_DATA;
                            walk = 0;
                        end
                    end
                end
                PH_DATA:
                begin
                    i = 7;
                    while (i >= 0 && ph == PH_DATA)
                    begin
                        walk = b[i] ? right_idx[walk] : left_idx[walk];
                        if (is_leaf[walk])
                        begin
                            remain = remain - 1;
                            emit(leaf_sym[walk], EV_SYM, remain == 0);
                            walk = 0;
                            if (remain == 0)
                                ph = PH_IDLE;
                        end
                        i--;
                    end
                end
                default: ph = PH_IDLE;
            endcase
            if (batch.size() > 0)
            begin
                batch[$].run_last = 1'b1;
                foreach (batch[k])
                    expected.push_back(batch[k]);
            end
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check(out_t r);
            out_t e;
            if (expected.size() == 0)
            begin
                report($sformatf("unexpected result %p", r));
                return;
            end
            e = expected.pop_front();
            if (r.event_res == EV_SYM)
                symbols_seen++;
            else
                events_seen++;
            if (r.symbol !== e.symbol)
                report($sformatf("symbol %h, wanted %h", r.symbol, e.symbol));
            if (r.event_res !== e.event_res)
                report($sformatf("event %0d, wanted %0d", r.event_res, e.event_res));
            if (r.run_last !== e.run_last)
                report($sformatf("run_last %b, wanted %b", r.run_last, e.run_last));
            if (r.stream_end !== e.stream_end)
                report($sformatf("stream_end %b, wanted %b", r.stream_end, e.stream_end));
        endtask
    endclass

    logic  clk;
    logic  rst_n;
    logic  byte_valid;
    logic  byte_stall;
    in_t   byte_data;
    logic  res_valid;
    logic  res_stall;
    out_t  res_data;

    huff_scoreboard sb;
    int send_pct;
    int recv_pct;
    int hold_req;
    int hold_left;
    int items;
    int files;
    int cycles;

    huffman_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check(res_data);
        if (hold_req != 0)
        begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= (recv_pct > 0) && ($urandom_range(99) < recv_pct);
        end
    end

    task automatic send(logic [7:0] b, bit fs);
        in_t t;
        int gap;
        t.data_byte = b;
        t.file_start = fs;
        if (send_pct > 0 && $urandom_range(99) < send_pct)
        begin
            byte_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data <= t;
        do @(posedge clk); while (byte_stall);
        sb.note(t);
        items++;
    endtask

    function automatic logic [7:0] inner_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == LEAF_MARK);
        return b;
    endfunction

    function automatic void grow(int depth, int limit, ref logic [7:0] q[$]);
        if (depth > 0 && (depth >= limit || $urandom_range(99) < 45))
        begin
            q.push_back(LEAF_MARK);
            q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            q.push_back(inner_byte());
            grow(depth + 1, limit, q);
            grow(depth + 1, limit, q);
        end
    endfunction

    task automatic send_file(int kind, int max_count);
        logic [7:0] hdr[$];
        logic [63:0] cnt;
        int cut;
        files++;
        grow(0, $urandom_range(1, 6), hdr);
        send(8'($urandom_range(0, 255)), 1'b1);
        cut = (kind == KIND_CUT) ? $urandom_range(1, hdr.size()) : hdr.size();
        for (int i = 0; i < cut; i++)
            send(hdr[i], 1'b0);
        if (kind == KIND_CUT)
            return;
        case (kind)
            KIND_ZERO: cnt = '0;
            KIND_NEG: cnt = {1'b1, 31'($urandom), 32'($urandom)};
            default: cnt = 64'($urandom_range(1, max_count));
        endcase
        for (int i = 0; i < 8; i++)
            send(cnt[8*i +: 8], 1'b0);
        while (sb.ph == PH_DATA)
            send(8'($urandom_range(0, 255)), 1'b0);
        repeat ($urandom_range(0, 2))
            send(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_error_file(bit zero_byte);
        files++;
        send(8'($urandom_range(0, 255)), 1'b1);
        if (!zero_byte)
        begin
            send(LEAF_MARK, 1'b0);
            send(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(0, 3))
                send(inner_byte(), 1'b0);
            send(8'h00, 1'b0);
        end
        send(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_overflow();
        files++;
        send(8'h00, 1'b1);
        repeat (NODE_LIMIT + 1)
            send(inner_byte(), 1'b0);
        send(8'h00, 1'b0);
    endtask

    initial
    begin
        int roll;
        clk = 1'b0;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_data = '0;
        res_stall = 1'b0;
        send_pct = 0;
        recv_pct = 0;
        hold_req = 0;
        hold_left = 0;
        items = 0;
        files = 0;
        cycles = 0;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(8'h00, 1'b1);
        send(8'hFF, 1'b0);
        send(LEAF_MARK, 1'b0);
        send(8'h00, 1'b0);
        send(8'h80, 1'b0);
        send(LEAF_MARK, 1'b0);
        send(8'hFF, 1'b0);
        send(LEAF_MARK, 1'b0);
        send(LEAF_MARK, 1'b0);
        send(8'h05, 1'b0);
        repeat (7) send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        send(8'h00, 1'b0);
        send(8'hFF, 1'b1);
        send(8'h00, 1'b0);
        send(8'h7E, 1'b1);
        send(LEAF_MARK, 1'b0);
        send(8'h7E, 1'b0);

        for (int mode = 0; mode < 3; mode++)
        begin
            send_pct = (mode == 0) ? 38 : (mode == 1) ? 45 : 0;
            recv_pct = (mode == 0) ? 45 : (mode == 1) ? 38 : 0;
            if (mode == 1)
            begin
                hold_req = 1;
                send_file(KIND_GOOD, 60);
            end
            if (mode == 2)
                send_overflow();
            while (items < 25 + 107 * (mode + 1) + ((mode == 2) ? NODE_LIMIT + 3 : 0))
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    send_file(KIND_GOOD, 24);
                else if (roll < 76)
                    send_error_file(1'b1);
                else if (roll < 82)
                    send_error_file(1'b0);
                else if (roll < 87)
                    send_file(KIND_ZERO, 1);
                else if (roll < 92)
                    send_file(KIND_NEG, 1);
                else
                    send_file(KIND_CUT, 1);
            end
        end

        byte_valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.expected.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected.size()));
        $display("ran %0d bytes over %0d files in %0d cycles", items, files, cycles);
        $display("checked %0d decoded symbols and %0d error events",
                 sb.symbols_seen, sb.events_seen);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: files.f
+incdir+sv
sv/hsd_pkg.sv
sv/hsd_ram.sv
sv/huffman_stream_decoder.sv
tb/testbench.sv
